/* rtl/occ_pkg.sv */
// Shared types, codes and constants for the ultrasonic occupancy counter.
package occ_pkg;

    localparam int EchoWidth  = 16;
    localparam int SumWidth   = 32;
    localparam int CountWidth = 8;
    localparam int TimerWidth = 16;
    localparam int CfgWidth   = 16;
    localparam int CfgIdxWidth = 2;

    localparam logic [CfgWidth-1:0] WindowLowReset    = 16'd588;
    localparam logic [CfgWidth-1:0] WindowHighReset   = 16'd1765;
    localparam logic [CfgWidth-1:0] WaitTimeoutReset  = 16'd1200;
    localparam logic [CfgWidth-1:0] ResetTimeoutReset = 16'd300;

    localparam logic signed [CountWidth-1:0] CountMax = 8'sd127;
    localparam logic signed [CountWidth-1:0] CountMin = -8'sd128;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_WINDOW_LOW    = 2'd0,
        REG_WINDOW_HIGH   = 2'd1,
        REG_WAIT_TIMEOUT  = 2'd2,
        REG_RESET_TIMEOUT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } light_ev_t;

    typedef struct packed {
        logic [CfgWidth-1:0] window_low_us;
        logic [CfgWidth-1:0] window_high_us;
        logic [CfgWidth-1:0] wait_timeout_ticks;
        logic [CfgWidth-1:0] reset_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [EchoWidth-1:0]         last_echo;
        logic signed [SumWidth-1:0]   variation_sum;
        logic signed [CountWidth-1:0] count_now;
        logic signed [CountWidth-1:0] count_seen;
        logic [TimerWidth-1:0]        wait_left;
        logic                         wait_armed;
        logic [TimerWidth-1:0]        grace_left;
        logic                         grace_armed;
    } state_t;

    typedef struct packed {
        light_ev_t                    light_event;
        logic signed [CountWidth-1:0] person_count;
        logic                         wait_running;
        logic                         reset_running;
    } result_t;

endpackage

/* rtl/occ_step.sv */
// Next-state and result logic for one sample or tick.
module occ_step
(
    input  occ_pkg::cfg_t                  cfg,
    input  occ_pkg::state_t                state,
    input  occ_pkg::opcode_t               opcode,
    input  logic [occ_pkg::EchoWidth-1:0]  echo_us,
    output occ_pkg::state_t                state_next,
    output occ_pkg::result_t               result
);

    localparam int WideWidth = occ_pkg::SumWidth + 2;
    localparam logic signed [WideWidth-1:0] SumMax =
        WideWidth'(signed'({1'b0, {(occ_pkg::SumWidth-1){1'b1}}}));
    localparam logic signed [WideWidth-1:0] SumMin =
        -WideWidth'(signed'({1'b0, 1'b1, {(occ_pkg::SumWidth-1){1'b0}}}));

    logic                         in_window;
    logic signed [WideWidth-1:0]  sum_wide;
    logic                         fired;
    occ_pkg::state_t              s;
    occ_pkg::light_ev_t           ev;

    assign in_window = (echo_us >= cfg.window_low_us) && (echo_us <= cfg.window_high_us);

    assign sum_wide = WideWidth'(state.variation_sum)
                    + signed'(WideWidth'({1'b0, state.last_echo}))
                    - signed'(WideWidth'({1'b0, echo_us}));

    always_comb
    begin
        s     = state;
        ev    = occ_pkg::EV_NONE;
        fired = 1'b0;

        unique case (opcode)
            occ_pkg::OP_SAMPLE:
            begin
                if (in_window)
                begin
                    if (state.last_echo != '0)
                    begin
                        priority if (sum_wide > SumMax)
                            s.variation_sum = SumMax[occ_pkg::SumWidth-1:0];
                        else if (sum_wide < SumMin)
                            s.variation_sum = SumMin[occ_pkg::SumWidth-1:0];
                        else
                            s.variation_sum = sum_wide[occ_pkg::SumWidth-1:0];
                    end
                    s.last_echo = echo_us;
                end
                else if (state.last_echo != '0)
                begin
                    if (state.variation_sum > 0 && state.count_now < occ_pkg::CountMax)
                        s.count_now = state.count_now + 8'sd1;
                    else if (state.variation_sum < 0 && state.count_now > occ_pkg::CountMin)
                        s.count_now = state.count_now - 8'sd1;
                    s.last_echo     = '0;
                    s.variation_sum = '0;
                end
            end
            occ_pkg::OP_TICK:
            begin
                if (state.wait_armed)
                begin
                    if (state.wait_left <= occ_pkg::TimerWidth'(1))
                    begin
                        s.wait_armed = 1'b0;
                        s.wait_left  = '0;
                        fired        = 1'b1;
                    end
                    else
                        s.wait_left = state.wait_left - occ_pkg::TimerWidth'(1);
                end
                if (state.grace_armed)
                begin
                    if (state.grace_left <= occ_pkg::TimerWidth'(1))
                    begin
                        s.grace_armed = 1'b0;
                        s.grace_left  = '0;
                        fired         = 1'b1;
                    end
                    else
                        s.grace_left = state.grace_left - occ_pkg::TimerWidth'(1);
                end
                if (fired)
                begin
                    s.count_now = '0;
                    if (s.count_seen < 0)
                        s.count_seen = 8'sd1;
                end
            end
            default:
            begin
                s = state;
            end
        endcase

        // entry rule
        if (s.count_now > 0 && s.count_now != s.count_seen)
        begin
            ev = occ_pkg::EV_ON;
            if (!s.wait_armed)
            begin
                s.wait_armed = 1'b1;
                s.wait_left  = cfg.wait_timeout_ticks;
            end
            else if (s.count_now > s.count_seen)
                s.wait_left = cfg.wait_timeout_ticks;
            s.count_seen = s.count_now;
        end

        // empty rule
        if (s.count_now == 0 && s.count_seen > 0)
        begin
            ev           = occ_pkg::EV_OFF;
            s.count_seen = '0;
            s.wait_armed = 1'b0;
        end

        // negative rule
        if (s.count_now < 0 || s.count_seen < 0)
        begin
            if (s.count_seen > s.count_now)
            begin
                if (!s.grace_armed)
                begin
                    s.grace_armed = 1'b1;
                    ev            = occ_pkg::EV_ON;
                end
                s.grace_left = cfg.reset_timeout_ticks;
                s.count_seen = s.count_now;
            end
            else if (s.count_seen < s.count_now)
            begin
                s.count_now   = 8'sd1;
                s.grace_armed = 1'b0;
            end
        end
    end

    assign state_next           = s;
    assign result.light_event   = ev;
    assign result.person_count  = s.count_now;
    assign result.wait_running  = s.wait_armed;
    assign result.reset_running = s.grace_armed;

endmodule

/* rtl/occ_skid.sv */
// Two-entry result buffer between the step logic and the output channel.
module occ_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  occ_pkg::result_t  push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output occ_pkg::result_t  out_data
);

    logic             head_valid_reg;
    logic             tail_valid_reg;
    occ_pkg::result_t head_reg;
    occ_pkg::result_t tail_reg;
    logic             pop;

    assign push_ready = !tail_valid_reg;
    assign out_valid  = head_valid_reg;
    assign out_data   = head_reg;
    assign pop        = head_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (tail_valid_reg)
                    tail_valid_reg <= 1'b0;
                else
                    head_valid_reg <= push;
            end
            else if (push)
            begin
                if (!head_valid_reg)
                    head_valid_reg <= 1'b1;
                else
                    tail_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (tail_valid_reg)
                head_reg <= tail_reg;
            else if (push)
                head_reg <= push_data;
        end
        else if (push)
        begin
            if (!head_valid_reg)
                head_reg <= push_data;
            else
                tail_reg <= push_data;
        end
    end

endmodule

/* rtl/ultrasonic_occupancy_counter.sv */
// Top level of the ultrasonic occupancy counter: config, state and output buffer.
// Each accepted result is registered into the result buffer and shown once earlier results are taken.
// Throughput: one sample or tick per cycle while in_ready is high; the combinational state update sets it.
// A two-entry result buffer keeps input open while one result waits.
// Reset: rst_n low clears pass, count and timer state and loads default config.
module ultrasonic_occupancy_counter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [occ_pkg::EchoWidth-1:0]         echo_us,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            light_event,
    output logic signed [occ_pkg::CountWidth-1:0] person_count,
    output logic                                  wait_running,
    output logic                                  reset_running,
    input  logic                                  cfg_we,
    input  logic [occ_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [occ_pkg::CfgWidth-1:0]          cfg_data
);

    occ_pkg::cfg_t    cfg_reg;
    occ_pkg::state_t  state_reg;
    occ_pkg::state_t  state_next;
    occ_pkg::result_t step_result;
    occ_pkg::result_t out_data;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low_us       <= occ_pkg::WindowLowReset;
            cfg_reg.window_high_us      <= occ_pkg::WindowHighReset;
            cfg_reg.wait_timeout_ticks  <= occ_pkg::WaitTimeoutReset;
            cfg_reg.reset_timeout_ticks <= occ_pkg::ResetTimeoutReset;
        end
        else if (cfg_we)
        begin
            unique case (occ_pkg::cfg_reg_t'(cfg_index))
                occ_pkg::REG_WINDOW_LOW:    cfg_reg.window_low_us       <= cfg_data;
                occ_pkg::REG_WINDOW_HIGH:   cfg_reg.window_high_us      <= cfg_data;
                occ_pkg::REG_WAIT_TIMEOUT:  cfg_reg.wait_timeout_ticks  <= cfg_data;
                occ_pkg::REG_RESET_TIMEOUT: cfg_reg.reset_timeout_ticks <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    occ_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .opcode     (occ_pkg::opcode_t'(opcode)),
        .echo_us    (echo_us),
        .state_next (state_next),
        .result     (step_result)
    );

    occ_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign light_event   = out_data.light_event;
    assign person_count  = out_data.person_count;
    assign wait_running  = out_data.wait_running;
    assign reset_running = out_data.reset_running;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("transfer gave no result");

    a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (light_event != 2'd3))
        else $error("undefined light event code");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("state changed without a transfer");
`endif

endmodule
